### hdl/skt_pkg.sv
// Shared constants, operation codes and control bundles of the sorted key table.
`default_nettype none

package skt_pkg;

   // Default table depth and fixed field widths.
   localparam int CAPACITY_DEFAULT = 128;
   localparam int KEY_W            = 32;
   localparam int PAY_W            = 64;
   localparam int POS_W            = 8;
   localparam int OP_W             = 2;
   localparam int INDEX_OUT_W      = 7;
   localparam int OCC_W            = 8;

   // Number of cells combined in the first level of the result tree.
   localparam int LEAF_SIZE        = 16;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
   localparam logic [OP_W-1:0] OP_READ   = 2'd3;

   // Controls broadcast from the sequencer to every cell.
   typedef struct packed {
      logic eval_en;
      logic do_insert;
      logic do_remove;
   } cell_ctl_type;

   // Stage enables of the result tree.
   typedef struct packed {
      logic level1_en;
      logic level2_en;
   } gather_ctl_type;

endpackage

`default_nettype wire

### hdl/skt_if.sv
// Request and response channel interfaces of the sorted key table.
`default_nettype none

interface skt_req_if;
   logic                                valid;
   logic                                ready;
   logic [skt_pkg::OP_W-1:0]            opcode;
   logic signed [skt_pkg::KEY_W-1:0]    entry_key;
   logic [skt_pkg::PAY_W-1:0]           entry_payload;
   logic [skt_pkg::POS_W-1:0]           read_position;

   modport source (output valid, opcode, entry_key, entry_payload, read_position,
                   input ready);
   modport sink (input valid, opcode, entry_key, entry_payload, read_position,
                 output ready);
endinterface

interface skt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                success;
   logic [skt_pkg::INDEX_OUT_W-1:0]     found_index;
   logic signed [skt_pkg::KEY_W-1:0]    found_key;
   logic [skt_pkg::PAY_W-1:0]           found_payload;
   logic [skt_pkg::OCC_W-1:0]           occupancy;

   modport source (output valid, success, found_index, found_key, found_payload, occupancy,
                   input ready);
   modport sink (input valid, success, found_index, found_key, found_payload, occupancy,
                 output ready);
endinterface

`default_nettype wire

### hdl/sorted_key_table.sv
// Top level of the sorted key table: sequencer, row of cells, result tree and response register.
//
// The table keeps up to CAPACITY entries (signed key plus payload) in ascending key order
// in a row of cells, one entry per cell. Every request passes through these steps in order:
// the cycle it is taken in, one in which all cells compare their keys with the request at
// once, the registered levels of the OR tree that pick out the addressed cell's entry
// and position, and a commit cycle in which insert or remove shifts every later cell
// by one place and the response register is loaded. A new request is taken once the
// previous one has committed, so requests never overlap; the commit waits while an
// earlier response is still held. Entries of equal key sit together, with a newly
// inserted entry placed ahead of them. No clearing pass is needed after reset: a cell
// counts as occupied when its position lies below the fill count.
`default_nettype none

module sorted_key_table #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   skt_req_if.sink  req_bus,
   skt_rsp_if.source rsp_bus
);
   import skt_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int PW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EVAL   = 3'd1;
   localparam logic [2:0] ST_GATHER = 3'd2;
   localparam logic [2:0] ST_REDUCE = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [OP_W-1:0]           opcode_ff;
   logic signed [KEY_W-1:0]   entry_key_ff;
   logic [PAY_W-1:0]          entry_payload_ff;
   logic [POS_W-1:0]          read_position_ff;
   logic [CNT_W-1:0]          count_ff, count_in;

   logic                      req_fire;
   logic                      commit_fire;
   logic                      table_full;
   logic                      position_ok;
   logic                      op_ok;
   cell_ctl_type              cell_ctl;
   gather_ctl_type            gather_ctl;

   logic [KEY_W-1:0]          key_arr     [CAPACITY];
   logic [PAY_W-1:0]          payload_arr [CAPACITY];
   logic [CAPACITY-1:0]       less_now_vec;
   logic [CAPACITY-1:0]       match_now_vec;
   logic [CAPACITY-1:0]       less_flag_vec;
   logic [CAPACITY-1:0]       hit_vec;

   logic                      tree_hit;
   logic [IDX_W-1:0]          tree_index;
   logic [KEY_W-1:0]          tree_key;
   logic [PAY_W-1:0]          tree_payload;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_success_ff, rsp_success_in;
   logic [INDEX_OUT_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [KEY_W-1:0]          rsp_key_ff, rsp_key_in;
   logic [PAY_W-1:0]          rsp_payload_ff, rsp_payload_in;
   logic [OCC_W-1:0]          rsp_occupancy_ff, rsp_occupancy_in;
   logic [IDX_W+INDEX_OUT_W-1:0] index_ext;
   logic [CNT_W+OCC_W-1:0]       count_ext;

   // Request handshake and commit condition.
   assign req_bus.ready = state_ff == ST_IDLE;
   assign req_fire      = req_bus.valid && (state_ff == ST_IDLE);
   assign commit_fire   = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_bus.ready);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_EVAL;
         ST_EVAL:   state_in = ST_GATHER;
         ST_GATHER: state_in = ST_REDUCE;
         ST_REDUCE: state_in = ST_COMMIT;
         ST_COMMIT: if (commit_fire) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request fields held for the whole operation.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         opcode_ff        <= req_bus.opcode;
         entry_key_ff     <= req_bus.entry_key;
         entry_payload_ff <= req_bus.entry_payload;
         read_position_ff <= req_bus.read_position;
      end
   end

   // Outcome of the request, known once the tree has settled.
   assign table_full  = count_ff == CNT_W'(CAPACITY);
   assign position_ok = (read_position_ff != '0) && (PW'(read_position_ff) <= PW'(count_ff));

   always_comb begin
      case (opcode_ff)
         OP_INSERT: op_ok = !table_full;
         OP_REMOVE,
         OP_FIND:   op_ok = tree_hit;
         OP_READ:   op_ok = position_ok;
         default:   op_ok = 1'b0;
      endcase
   end

   assign cell_ctl.eval_en   = state_ff == ST_EVAL;
   assign cell_ctl.do_insert = commit_fire && (opcode_ff == OP_INSERT) && op_ok;
   assign cell_ctl.do_remove = commit_fire && (opcode_ff == OP_REMOVE) && op_ok;
   assign gather_ctl.level1_en = state_ff == ST_GATHER;
   assign gather_ctl.level2_en = state_ff == ST_REDUCE;

   // Fill count.
   always_comb begin
      count_in = count_ff;
      if (cell_ctl.do_insert) begin
         count_in = count_ff + 1'b1;
      end else if (cell_ctl.do_remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Row of cells, each wired to its left and right neighbours.
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [KEY_W-1:0] prev_key;
      logic [PAY_W-1:0] prev_payload;
      logic             prev_less;
      logic             prev_match;
      logic             prev_less_flag;
      logic [KEY_W-1:0] next_key;
      logic [PAY_W-1:0] next_payload;

      if (k == 0) begin : g_first
         assign prev_key       = '0;
         assign prev_payload   = '0;
         assign prev_less      = 1'b0;
         assign prev_match     = 1'b0;
         assign prev_less_flag = 1'b0;
      end else begin : g_inner_prev
         assign prev_key       = key_arr[k-1];
         assign prev_payload   = payload_arr[k-1];
         assign prev_less      = less_now_vec[k-1];
         assign prev_match     = match_now_vec[k-1];
         assign prev_less_flag = less_flag_vec[k-1];
      end

      if (k == CAPACITY - 1) begin : g_last
         assign next_key     = key_arr[k];
         assign next_payload = payload_arr[k];
      end else begin : g_inner_next
         assign next_key     = key_arr[k+1];
         assign next_payload = payload_arr[k+1];
      end

      skt_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (k)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctl            (cell_ctl),
         .opcode         (opcode_ff),
         .entry_key      (entry_key_ff),
         .entry_payload  (entry_payload_ff),
         .read_position  (read_position_ff),
         .count          (count_ff),
         .prev_key       (prev_key),
         .prev_payload   (prev_payload),
         .prev_less      (prev_less),
         .prev_match     (prev_match),
         .prev_less_flag (prev_less_flag),
         .next_key       (next_key),
         .next_payload   (next_payload),
         .key_ff         (key_arr[k]),
         .payload_ff     (payload_arr[k]),
         .less_now       (less_now_vec[k]),
         .match_now      (match_now_vec[k]),
         .less_flag_ff   (less_flag_vec[k]),
         .hit_flag_ff    (hit_vec[k])
      );
   end

   // Result tree over the addressed cell.
   skt_gather #(
      .CAPACITY (CAPACITY)
   ) u_gather (
      .clock      (clock),
      .reset      (reset),
      .ctl        (gather_ctl),
      .hit        (hit_vec),
      .key        (key_arr),
      .payload    (payload_arr),
      .any_hit_ff (tree_hit),
      .index_ff   (tree_index),
      .key_ff     (tree_key),
      .payload_ff (tree_payload)
   );

   // Response fields; a failed request reports zero index, key and payload, and only find
   // and read return the entry itself.
   assign index_ext = {{INDEX_OUT_W{1'b0}}, tree_index};
   assign count_ext = {{OCC_W{1'b0}}, count_in};

   always_comb begin
      rsp_success_in   = op_ok;
      rsp_index_in     = op_ok ? index_ext[INDEX_OUT_W-1:0] : '0;
      rsp_occupancy_in = count_ext[OCC_W-1:0];
      rsp_key_in       = '0;
      rsp_payload_in   = '0;
      if (op_ok && ((opcode_ff == OP_FIND) || (opcode_ff == OP_READ))) begin
         rsp_key_in     = tree_key;
         rsp_payload_in = tree_payload;
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (commit_fire) begin
         rsp_success_ff   <= rsp_success_in;
         rsp_index_ff     <= rsp_index_in;
         rsp_key_ff       <= rsp_key_in;
         rsp_payload_ff   <= rsp_payload_in;
         rsp_occupancy_ff <= rsp_occupancy_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.success       = rsp_success_ff;
   assign rsp_bus.found_index   = rsp_index_ff;
   assign rsp_bus.found_key     = rsp_key_ff;
   assign rsp_bus.found_payload = rsp_payload_ff;
   assign rsp_bus.occupancy     = rsp_occupancy_ff;

`ifndef SYNTHESIS
   // The fill count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count exceeds table depth");

   // At most one cell claims a request once the flags are held.
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GATHER) |-> $onehot0(hit_vec))
      else $error("more than one cell addressed");

   // A response only appears out of the commit cycle.
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_COMMIT))
      else $error("response raised outside commit");

   // A successful insert grows the table by exactly one entry.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cell_ctl.do_insert |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("insert did not grow the table");
`endif

endmodule

`default_nettype wire

### hdl/skt_cell.sv
// One slot of the sorted table: holds an entry, compares it and shifts with its neighbours.
`default_nettype none

module skt_cell #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT,
   parameter int INDEX    = 0,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire skt_pkg::cell_ctl_type            ctl,
   input  wire logic [skt_pkg::OP_W-1:0]         opcode,
   input  wire logic signed [skt_pkg::KEY_W-1:0] entry_key,
   input  wire logic [skt_pkg::PAY_W-1:0]        entry_payload,
   input  wire logic [skt_pkg::POS_W-1:0]        read_position,
   input  wire logic [CNT_W-1:0]                 count,
   input  wire logic [skt_pkg::KEY_W-1:0]        prev_key,
   input  wire logic [skt_pkg::PAY_W-1:0]        prev_payload,
   input  wire logic                             prev_less,
   input  wire logic                             prev_match,
   input  wire logic                             prev_less_flag,
   input  wire logic [skt_pkg::KEY_W-1:0]        next_key,
   input  wire logic [skt_pkg::PAY_W-1:0]        next_payload,
   output logic [skt_pkg::KEY_W-1:0]             key_ff,
   output logic [skt_pkg::PAY_W-1:0]             payload_ff,
   output logic                                  less_now,
   output logic                                  match_now,
   output logic                                  less_flag_ff,
   output logic                                  hit_flag_ff
);
   import skt_pkg::*;

   localparam int PW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam logic [CNT_W-1:0] MY_SLOT     = CNT_W'(INDEX);
   localparam logic [PW-1:0]    MY_POSITION = PW'(INDEX + 1);

   logic             occupied;
   logic             hit_now;
   logic [KEY_W-1:0] key_in;
   logic [PAY_W-1:0] payload_in;

   // The slot holds a live entry when it lies below the fill count.
   assign occupied  = MY_SLOT < count;
   assign less_now  = occupied && ($signed(key_ff) < entry_key);
   assign match_now = occupied && ($signed(key_ff) == entry_key);

   // This slot is the one the request addresses. Equal keys sit together in a
   // sorted table, so the first match is the match whose left neighbour differs.
   always_comb begin
      case (opcode)
         OP_INSERT: hit_now = !less_now && ((INDEX == 0) || prev_less);
         OP_REMOVE,
         OP_FIND:   hit_now = match_now && !prev_match;
         OP_READ:   hit_now = PW'(read_position) == MY_POSITION;
         default:   hit_now = 1'b0;
      endcase
   end

   // Comparison flags held for the tree and for the shift.
   always_ff @(posedge clock) begin
      if (reset) begin
         less_flag_ff <= 1'b0;
         hit_flag_ff  <= 1'b0;
      end else if (ctl.eval_en) begin
         less_flag_ff <= less_now;
         hit_flag_ff  <= hit_now;
      end
   end

   // Insert opens a gap at the boundary and moves later entries up; remove
   // pulls later entries down over the first match.
   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      if (ctl.do_insert && !less_flag_ff) begin
         if ((INDEX == 0) || prev_less_flag) begin
            key_in     = entry_key;
            payload_in = entry_payload;
         end else begin
            key_in     = prev_key;
            payload_in = prev_payload;
         end
      end else if (ctl.do_remove && !less_flag_ff && (INDEX != CAPACITY - 1)) begin
         key_in     = next_key;
         payload_in = next_payload;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

endmodule

`default_nettype wire

### hdl/skt_gather.sv
// Two-level registered OR tree that collects the addressed cell's entry and position.
`default_nettype none

module skt_gather #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT,
   localparam int IDX_W   = $clog2(CAPACITY)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire skt_pkg::gather_ctl_type   ctl,
   input  wire logic [CAPACITY-1:0]       hit,
   input  wire logic [skt_pkg::KEY_W-1:0] key [CAPACITY],
   input  wire logic [skt_pkg::PAY_W-1:0] payload [CAPACITY],
   output logic                           any_hit_ff,
   output logic [IDX_W-1:0]               index_ff,
   output logic [skt_pkg::KEY_W-1:0]      key_ff,
   output logic [skt_pkg::PAY_W-1:0]      payload_ff
);
   import skt_pkg::*;

   localparam int NGRP = (CAPACITY + LEAF_SIZE - 1) / LEAF_SIZE;

   logic             grp_hit_in     [NGRP];
   logic [IDX_W-1:0] grp_index_in   [NGRP];
   logic [KEY_W-1:0] grp_key_in     [NGRP];
   logic [PAY_W-1:0] grp_payload_in [NGRP];
   logic             grp_hit_ff     [NGRP];
   logic [IDX_W-1:0] grp_index_ff   [NGRP];
   logic [KEY_W-1:0] grp_key_ff     [NGRP];
   logic [PAY_W-1:0] grp_payload_ff [NGRP];
   logic             any_hit_in;
   logic [IDX_W-1:0] index_in;
   logic [KEY_W-1:0] key_in;
   logic [PAY_W-1:0] payload_in;

   // First level: each group ORs the masked contents of its cells.
   always_comb begin
      int slot;
      for (int g = 0; g < NGRP; g++) begin
         grp_hit_in[g]     = 1'b0;
         grp_index_in[g]   = '0;
         grp_key_in[g]     = '0;
         grp_payload_in[g] = '0;
         for (int j = 0; j < LEAF_SIZE; j++) begin
            slot = g * LEAF_SIZE + j;
            if (slot < CAPACITY) begin
               if (hit[slot]) begin
                  grp_hit_in[g]     = 1'b1;
                  grp_index_in[g]   = grp_index_in[g] | IDX_W'(slot);
                  grp_key_in[g]     = grp_key_in[g] | key[slot];
                  grp_payload_in[g] = grp_payload_in[g] | payload[slot];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NGRP; g++) begin
         if (reset) begin
            grp_hit_ff[g] <= 1'b0;
         end else if (ctl.level1_en) begin
            grp_hit_ff[g] <= grp_hit_in[g];
         end
         if (ctl.level1_en) begin
            grp_index_ff[g]   <= grp_index_in[g];
            grp_key_ff[g]     <= grp_key_in[g];
            grp_payload_ff[g] <= grp_payload_in[g];
         end
      end
   end

   // Second level: OR across the groups, of which at most one is hit.
   always_comb begin
      any_hit_in = 1'b0;
      index_in   = '0;
      key_in     = '0;
      payload_in = '0;
      for (int g = 0; g < NGRP; g++) begin
         if (grp_hit_ff[g]) begin
            any_hit_in = 1'b1;
            index_in   = index_in | grp_index_ff[g];
            key_in     = key_in | grp_key_ff[g];
            payload_in = payload_in | grp_payload_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_hit_ff <= 1'b0;
      end else if (ctl.level2_en) begin
         any_hit_ff <= any_hit_in;
      end
      if (ctl.level2_en) begin
         index_ff   <= index_in;
         key_ff     <= key_in;
         payload_ff <= payload_in;
      end
   end

endmodule

`default_nettype wire

### bench/sorted_key_table_tb.sv
// Self-checking testbench for the sorted key table, with a predictor, driver and monitor.
`timescale 1ns / 100ps

module sorted_key_table_tb;

   import skt_pkg::*;

   localparam int TABLE_DEPTH     = CAPACITY_DEFAULT;
   localparam int RANDOM_REQUESTS = 1900;
   localparam int STALL_LIMIT     = 4000;
   localparam int SETTLE_CYCLES   = 20;
   localparam int HOLD_CYCLES     = 150;

   // One table request, tagged with the idling phase it belongs to.
   typedef struct packed {
      logic [OP_W-1:0]         opcode;
      logic signed [KEY_W-1:0] key;
      logic [PAY_W-1:0]        payload;
      logic [POS_W-1:0]        position;
      int unsigned             phase;
   } table_req_type;

   // One table response.
   typedef struct packed {
      logic                       success;
      logic [INDEX_OUT_W-1:0]     index;
      logic signed [KEY_W-1:0]    key;
      logic [PAY_W-1:0]           payload;
      logic [OCC_W-1:0]           occupancy;
   } table_rsp_type;

   // Kinds of random burst.
   typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX, BURST_NOISE} burst_kind_type;

   logic clock;
   logic reset;

   skt_req_if req_bus ();
   skt_rsp_if rsp_bus ();

   sorted_key_table u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Two copies of the table contents: copy 0 follows the stimulus as it is planned,
   // copy 1 follows the requests as the block accepts them.
   logic signed [KEY_W-1:0] key_tab [0:1][0:TABLE_DEPTH-1];
   logic [PAY_W-1:0]        pay_tab [0:1][0:TABLE_DEPTH-1];
   int                      fill [0:1];

   table_req_type  pending_reqs [$];
   table_rsp_type  expected_rsps [$];
   int unsigned idle_phase;
   int          error_count;
   int          rsp_seen;
   int          hold_left;
   int          quiet_cycles;

   always #4 clock = ~clock;

   // Applies one request to the chosen copy of the table and returns its response.
   function automatic table_rsp_type apply_request(input int sel, input table_req_type rq);
      table_rsp_type rs;
      int         n;
      int         slot;
      int         k;
      n = fill[sel];
      rs = '0;
      rs.occupancy = n[OCC_W-1:0];
      case (rq.opcode)
         OP_INSERT: begin
            if (n < TABLE_DEPTH) begin
               // New entry goes ahead of every entry whose key is not smaller.
               slot = 0;
               while (slot < n && key_tab[sel][slot] < rq.key) slot++;
               for (k = n; k > slot; k--) begin
                  key_tab[sel][k] = key_tab[sel][k-1];
                  pay_tab[sel][k] = pay_tab[sel][k-1];
               end
               key_tab[sel][slot] = rq.key;
               pay_tab[sel][slot] = rq.payload;
               fill[sel] = n + 1;
               rs.success = 1'b1;
               rs.index = slot[INDEX_OUT_W-1:0];
               rs.occupancy = fill[sel][OCC_W-1:0];
            end
         end
         OP_REMOVE, OP_FIND: begin
            slot = 0;
            while (slot < n && key_tab[sel][slot] != rq.key) slot++;
            if (slot < n) begin
               rs.success = 1'b1;
               rs.index = slot[INDEX_OUT_W-1:0];
               if (rq.opcode == OP_FIND) begin
                  rs.key = key_tab[sel][slot];
                  rs.payload = pay_tab[sel][slot];
               end else begin
                  // Close the gap left by the removed entry.
                  for (k = slot; k + 1 < n; k++) begin
                     key_tab[sel][k] = key_tab[sel][k+1];
                     pay_tab[sel][k] = pay_tab[sel][k+1];
                  end
                  fill[sel] = n - 1;
                  rs.occupancy = fill[sel][OCC_W-1:0];
               end
            end
         end
         default: begin
            if (rq.position != 0 && rq.position <= n) begin
               slot = rq.position - 1;
               rs.success = 1'b1;
               rs.index = slot[INDEX_OUT_W-1:0];
               rs.key = key_tab[sel][slot];
               rs.payload = pay_tab[sel][slot];
            end
         end
      endcase
      return rs;
   endfunction

   function automatic table_req_type make_req(input logic [OP_W-1:0] op,
                                              input logic signed [KEY_W-1:0] key,
                                              input logic [PAY_W-1:0] payload,
                                              input logic [POS_W-1:0] position);
      table_req_type rq;
      rq.opcode = op;
      rq.key = key;
      rq.payload = payload;
      rq.position = position;
      rq.phase = 0;
      return rq;
   endfunction

   // Plans a request: the planning copy of the table moves on with it.
   function automatic void queue_request(input table_req_type rq);
      void'(apply_request(0, rq));
      pending_reqs.push_back(rq);
   endfunction

   // Picks a key, mostly one already stored when a hit is wanted.
   function automatic logic signed [KEY_W-1:0] choose_key(input bit want_hit);
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (want_hit && fill[0] != 0 && r < 75) return key_tab[0][$urandom_range(0, fill[0] - 1)];
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sh00000000;
            default: return 32'shffffffff;
         endcase
      end
      if (r < 5) begin
         // A narrow range, so that equal keys pile up.
         v = $urandom_range(0, 16);
         return v - 8;
      end
      return $urandom;
   endfunction

   // Stimulus, reset and the end of the run.
   initial begin
      table_req_type  rq;
      burst_kind_type kind;
      int          made;
      int          burst_len;
      int          j;
      int          p;
      int          q;
      int          n;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_INSERT;
      req_bus.entry_key = '0;
      req_bus.entry_payload = '0;
      req_bus.read_position = '0;
      rsp_bus.ready = 1'b0;
      error_count = 0;
      rsp_seen = 0;
      hold_left = 0;
      quiet_cycles = 0;
      idle_phase = 0;
      fill[0] = 0;
      fill[1] = 0;

      // Directed part: empty table, key extremes, equal keys and bad positions.
      queue_request(make_req(OP_REMOVE, 32'sd5, {$urandom, $urandom}, 8'd1));
      queue_request(make_req(OP_FIND, 32'sd5, {$urandom, $urandom}, 8'd1));
      queue_request(make_req(OP_READ, 32'sd5, {$urandom, $urandom}, 8'd0));
      queue_request(make_req(OP_READ, 32'sd5, {$urandom, $urandom}, 8'd1));
      queue_request(make_req(OP_INSERT, 32'sh7fffffff, 64'hffff_ffff_ffff_ffff, 8'd0));
      queue_request(make_req(OP_INSERT, 32'sh80000000, 64'h0, 8'd255));
      queue_request(make_req(OP_INSERT, 32'sd0, 64'h0123_4567_89ab_cdef, 8'd3));
      queue_request(make_req(OP_INSERT, 32'sd0, 64'hfedc_ba98_7654_3210, 8'd3));
      queue_request(make_req(OP_INSERT, -32'sd1, 64'haaaa_5555_aaaa_5555, 8'd0));
      queue_request(make_req(OP_READ, 32'sd0, {$urandom, $urandom}, 8'd1));
      queue_request(make_req(OP_READ, 32'sd0, {$urandom, $urandom}, 8'd5));
      queue_request(make_req(OP_READ, 32'sd0, {$urandom, $urandom}, 8'd6));
      queue_request(make_req(OP_READ, 32'sd0, {$urandom, $urandom}, 8'd255));
      queue_request(make_req(OP_FIND, 32'sd0, {$urandom, $urandom}, 8'd0));
      queue_request(make_req(OP_FIND, 32'sd12345, {$urandom, $urandom}, 8'd0));
      queue_request(make_req(OP_REMOVE, 32'sd0, {$urandom, $urandom}, 8'd0));
      queue_request(make_req(OP_FIND, 32'sd0, {$urandom, $urandom}, 8'd0));
      queue_request(make_req(OP_REMOVE, 32'sh80000000, {$urandom, $urandom}, 8'd0));
      queue_request(make_req(OP_REMOVE, 32'sh7fffffff, {$urandom, $urandom}, 8'd0));
      queue_request(make_req(OP_READ, 32'sd0, {$urandom, $urandom}, 8'd3));
      queue_request(make_req(OP_REMOVE, 32'sd99, {$urandom, $urandom}, 8'd0));

      // Random part: bursts that fill the table past full, drain it past empty,
      // mix all operations, or throw raw noise at it.
      made = 0;
      while (made < RANDOM_REQUESTS) begin
         p = $urandom_range(0, 9);
         kind = p < 3 ? BURST_FILL : p < 6 ? BURST_DRAIN : p < 9 ? BURST_MIX : BURST_NOISE;
         case (kind)
            BURST_FILL, BURST_DRAIN: burst_len = $urandom_range(100, 220);
            BURST_MIX:               burst_len = $urandom_range(30, 120);
            default:                 burst_len = $urandom_range(10, 40);
         endcase
         for (j = 0; j < burst_len && made < RANDOM_REQUESTS; j++) begin
            p = $urandom_range(0, 99);
            n = fill[0];
            rq.payload = {$urandom, $urandom};
            rq.phase = made * 3 / RANDOM_REQUESTS;
            if (kind == BURST_NOISE) begin
               rq.opcode = OP_W'($urandom_range(0, 3));
               rq.key = $urandom;
               rq.position = POS_W'($urandom_range(0, 255));
            end else begin
               case (kind)
                  BURST_FILL:
                     rq.opcode = p < 80 ? OP_INSERT : p < 88 ? OP_FIND : p < 94 ? OP_READ
                                : OP_REMOVE;
                  BURST_DRAIN:
                     rq.opcode = p < 75 ? OP_REMOVE : p < 85 ? OP_FIND : p < 95 ? OP_READ
                                : OP_INSERT;
                  default:
                     rq.opcode = p < 30 ? OP_INSERT : p < 55 ? OP_REMOVE : p < 80 ? OP_FIND
                                : OP_READ;
               endcase
               if (rq.opcode == OP_INSERT) rq.key = choose_key($urandom_range(0, 3) == 0);
               else rq.key = choose_key(1'b1);
               q = $urandom_range(0, 99);
               if (q < 70 && n > 0) rq.position = POS_W'($urandom_range(1, n));
               else if (q < 80) rq.position = '0;
               else if (q < 90) rq.position = POS_W'(n + 1);
               else rq.position = POS_W'($urandom_range(0, 255));
            end
            queue_request(rq);
            made++;
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and answered, then let the block settle.
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("sorted_key_table_tb OK");
      end else begin
         $display("sorted_key_table_tb NOT OK");
      end
      $finish;
   end

   // Request driver: offers the oldest pending request, predicting its response
   // when the block takes it.
   always @(posedge clock) begin : request_driver
      table_rsp_type predicted;
      int         gap_pct;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predicted = apply_request(1, pending_reqs[0]);
            expected_rsps.push_back(predicted);
            idle_phase <= pending_reqs[0].phase;
            void'(pending_reqs.pop_front());
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            // A request still waiting keeps its valid; otherwise maybe leave a gap.
            if (pending_reqs.size() != 0) begin
               gap_pct = pending_reqs[0].phase == 0 ? 6 : pending_reqs[0].phase == 1 ? 69 : 0;
            end else begin
               gap_pct = 100;
            end
            if ($urandom_range(0, 99) >= gap_pct) begin
               req_bus.valid <= 1'b1;
               req_bus.opcode <= pending_reqs[0].opcode;
               req_bus.entry_key <= pending_reqs[0].key;
               req_bus.entry_payload <= pending_reqs[0].payload;
               req_bus.read_position <= pending_reqs[0].position;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(input string field, input logic [PAY_W-1:0] want,
                                  input logic [PAY_W-1:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      error_count++;
   endtask

   // Response monitor: checks each response against the oldest expectation and
   // drives ready, with two long hold-offs so that the block backs up.
   always @(posedge clock) begin : response_monitor
      table_rsp_type want;
      table_rsp_type got;
      int         stall_pct;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_seen++;
            got.success = rsp_bus.success;
            got.index = rsp_bus.found_index;
            got.key = rsp_bus.found_key;
            got.payload = rsp_bus.found_payload;
            got.occupancy = rsp_bus.occupancy;
            if (expected_rsps.size() == 0) begin
               $display("%0t: response with none expected, actual %h", $time, got);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.success !== want.success)
                  report_mismatch("success", PAY_W'(want.success), PAY_W'(got.success));
               if (got.index !== want.index)
                  report_mismatch("found_index", PAY_W'(want.index), PAY_W'(got.index));
               if (got.key !== want.key)
                  report_mismatch("found_key", PAY_W'(want.key), PAY_W'(got.key));
               if (got.payload !== want.payload)
                  report_mismatch("found_payload", want.payload, got.payload);
               if (got.occupancy !== want.occupancy)
                  report_mismatch("occupancy", PAY_W'(want.occupancy),
                                  PAY_W'(got.occupancy));
            end
            if (rsp_seen == 100 || rsp_seen == 1500) hold_left = HOLD_CYCLES;
         end
         stall_pct = idle_phase == 0 ? 69 : idle_phase == 1 ? 6 : 0;
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= $urandom_range(0, 99) >= stall_pct;
         end
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin : watchdog
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("sorted_key_table_tb NOT OK");
         $finish;
      end
   end

endmodule
